FILE: design/llcp_pkg.sv
// Shared types, widths and constants for the line/line closest-point pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package llcp_pkg;

	// coordinate width (Q16.16 at 32 bits)
	localparam int COORD_WIDTH = 32;

	// derived widths
	localparam int DW   = COORD_WIDTH + 1;   // edge vector / offset component
	localparam int PRW  = 2 * DW;            // product of two components
	localparam int PW   = 2 * DW + 1;        // dot product, signed
	localparam int FW   = 2 * PW;            // denominator / numerators, signed
	localparam int NW   = FW + DW;           // numerator times component, signed
	localparam int HW   = PW / 2;            // half of a dot-product magnitude
	localparam int KW   = DW + 1;            // slice of a numerator magnitude
	localparam int NSL  = (FW - 1 + KW - 1) / KW;
	localparam int DENW = FW - 1;            // denominator magnitude
	localparam int QB   = 63;                // quotient bits kept
	localparam int QW   = QB + 1;            // plus one rounding step
	localparam int SUMW = 65;

	// pipeline latencies and stage numbers
	localparam int L_WMUL   = 5;
	localparam int L_NMUL   = 5;
	localparam int L_DIV    = QW + 4;
	localparam int ST_DOT   = 3;
	localparam int ST_WMUL  = ST_DOT + L_WMUL;
	localparam int ST_FAC   = ST_WMUL + 1;
	localparam int ST_NMUL  = ST_FAC + L_NMUL;
	localparam int ST_DIV   = ST_NMUL + L_DIV;

	localparam logic [QB-1:0] QCLAMP = QB'(64'h4000_0000_0000_0000);
	localparam logic signed [SUMW-1:0] SUM_MAX = (SUMW'(1) <<< (COORD_WIDTH - 1)) - SUMW'(1);
	localparam logic signed [SUMW-1:0] SUM_MIN = ~SUM_MAX;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic signed [PRW-1:0]         prod_t;
	typedef logic signed [PW-1:0]          dot_t;
	typedef logic signed [FW-1:0]          wide_t;
	typedef logic signed [NW-1:0]          num_t;
	typedef logic [DENW-1:0]               den_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_start_z;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t a_end_z;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_start_z;
		coord_t b_end_x;
		coord_t b_end_y;
		coord_t b_end_z;
	} in_item_t;

	typedef struct packed {
		coord_t near_a_x;
		coord_t near_a_y;
		coord_t near_a_z;
		coord_t near_b_x;
		coord_t near_b_y;
		coord_t near_b_z;
		logic   lines_parallel;
	} out_item_t;

	// side data that rides along the divider stages
	typedef struct packed {
		coord_t base;
		logic   keep;
		logic   neg;
		logic   ovf;
	} dctl_t;

endpackage

FILE: design/llcp_in_if.sv
// Request channel carrying edge A and edge B into the block.
// Depends on llcp_pkg.
`timescale 1ns / 1ps

interface llcp_in_if;
	import llcp_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: design/llcp_out_if.sv
// Result channel carrying the two closest points out of the block.
// Depends on llcp_pkg.
`timescale 1ns / 1ps

interface llcp_out_if;
	import llcp_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: design/line_line_closest_points.sv
// Top level: closest points between two infinite 3D lines, fixed point.
// Depends on llcp_pkg, llcp_in_if, llcp_out_if, llcp_wmul, llcp_nmul, llcp_div.
`timescale 1ns / 1ps

// Each request on "edges" carries the endpoints of edge A and edge B in signed
// Q16.16; each result on "points" gives the closest point on each infinite
// line, rounded to nearest (ties away from zero) and saturated to the
// coordinate range. When the denominator |a|^2|b|^2-(a.b)^2 is zero (parallel
// lines or a zero-length edge) the start points come back and lines_parallel
// is set. The block takes one request per clock while the output is not
// stalled and returns one result per request, in order. The pipeline has
// 3 stages for the edge vectors and dot products, 5 for the wide products,
// 1 for the denominator and numerators, 5 for the numerator scaling, 68 in
// the dividers (one quotient bit per stage, 63 bits plus a rounding bit), then
// the output register. A stalled output freezes the whole pipeline in place.
module line_line_closest_points (
	input  logic clk,
	input  logic arst_n,
	llcp_in_if.sink    edges,
	llcp_out_if.source points
);
	import llcp_pkg::*;

	// global advance: the output register is empty or being drained
	logic adv;
	logic out_valid_q;
	out_item_t out_item_q;
	logic vld_s [1:ST_DIV];

	assign adv          = !out_valid_q || points.ready;
	assign edges.ready  = adv;
	assign points.valid = out_valid_q;
	assign points.item  = out_item_q;

	// stage 1: start points and edge/offset vectors
	coord_t a0_c [3], a1_c [3], b0_c [3], b1_c [3];
	coord_t a0_d [1:ST_NMUL][3];
	coord_t b0_d [1:ST_NMUL][3];
	diff_t  ta_d [1:ST_FAC][3];
	diff_t  tb_d [1:ST_FAC][3];
	diff_t  dd_s1 [3];

	assign a0_c[0] = edges.item.a_start_x;
	assign a0_c[1] = edges.item.a_start_y;
	assign a0_c[2] = edges.item.a_start_z;
	assign a1_c[0] = edges.item.a_end_x;
	assign a1_c[1] = edges.item.a_end_y;
	assign a1_c[2] = edges.item.a_end_z;
	assign b0_c[0] = edges.item.b_start_x;
	assign b0_c[1] = edges.item.b_start_y;
	assign b0_c[2] = edges.item.b_start_z;
	assign b1_c[0] = edges.item.b_end_x;
	assign b1_c[1] = edges.item.b_end_y;
	assign b1_c[2] = edges.item.b_end_z;

	// stage 2: component products, stage 3: dot products
	prod_t taa_s2 [3], tbb_s2 [3], tab_s2 [3], tad_s2 [3], tbd_s2 [3];
	dot_t  la_s3, lb_s3, lab_s3, tad_s3, tbd_s3;

	// stages 4..8: wide products
	wide_t w_lalb, w_lablab, w_lbtad, w_labtbd, w_labtad, w_latbd;

	// stage 9: denominator and the two numerators
	wide_t fac_d [ST_FAC:ST_NMUL];
	wide_t numa_s9, numb_s9;
	logic  par_d [ST_FAC+1:ST_NMUL];

	// stages 10..14: numerators scaled by edge components
	num_t na_c [3], nb_c [3];

	// stages 15..82: divide, round, add start point
	coord_t ca_c [3], cb_c [3];
	logic   ka_c [3], kb_c [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a0_d[1][i] <= a0_c[i];
				b0_d[1][i] <= b0_c[i];
				ta_d[1][i] <= diff_t'(a1_c[i]) - diff_t'(a0_c[i]);
				tb_d[1][i] <= diff_t'(b1_c[i]) - diff_t'(b0_c[i]);
				dd_s1[i]   <= diff_t'(b0_c[i]) - diff_t'(a0_c[i]);
			end
			for (int k = 2; k <= ST_NMUL; k++) begin
				a0_d[k] <= a0_d[k-1];
				b0_d[k] <= b0_d[k-1];
			end
			for (int k = 2; k <= ST_FAC; k++) begin
				ta_d[k] <= ta_d[k-1];
				tb_d[k] <= tb_d[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				taa_s2[i] <= prod_t'(ta_d[1][i]) * prod_t'(ta_d[1][i]);
				tbb_s2[i] <= prod_t'(tb_d[1][i]) * prod_t'(tb_d[1][i]);
				tab_s2[i] <= prod_t'(ta_d[1][i]) * prod_t'(tb_d[1][i]);
				tad_s2[i] <= prod_t'(ta_d[1][i]) * prod_t'(dd_s1[i]);
				tbd_s2[i] <= prod_t'(tb_d[1][i]) * prod_t'(dd_s1[i]);
			end

			la_s3  <= PW'(taa_s2[0]) + PW'(taa_s2[1]) + PW'(taa_s2[2]);
			lb_s3  <= PW'(tbb_s2[0]) + PW'(tbb_s2[1]) + PW'(tbb_s2[2]);
			lab_s3 <= PW'(tab_s2[0]) + PW'(tab_s2[1]) + PW'(tab_s2[2]);
			tad_s3 <= PW'(tad_s2[0]) + PW'(tad_s2[1]) + PW'(tad_s2[2]);
			tbd_s3 <= PW'(tbd_s2[0]) + PW'(tbd_s2[1]) + PW'(tbd_s2[2]);

			fac_d[ST_FAC] <= w_lalb - w_lablab;
			numa_s9       <= w_lbtad - w_labtbd;
			numb_s9       <= w_labtad - w_latbd;
			for (int k = ST_FAC + 1; k <= ST_NMUL; k++)
				fac_d[k] <= fac_d[k-1];

			// fac is never negative; zero means no unique solution
			par_d[ST_FAC+1] <= (fac_d[ST_FAC] == '0) || fac_d[ST_FAC][FW-1];
			for (int k = ST_FAC + 2; k <= ST_NMUL; k++)
				par_d[k] <= par_d[k-1];

			out_item_q.near_a_x       <= ca_c[0];
			out_item_q.near_a_y       <= ca_c[1];
			out_item_q.near_a_z       <= ca_c[2];
			out_item_q.near_b_x       <= cb_c[0];
			out_item_q.near_b_y       <= cb_c[1];
			out_item_q.near_b_z       <= cb_c[2];
			out_item_q.lines_parallel <= ka_c[0];
		end
	end

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_DIV; k++)
				vld_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= edges.valid;
			for (int k = 2; k <= ST_DIV; k++)
				vld_s[k] <= vld_s[k-1];
			out_valid_q <= vld_s[ST_DIV];
		end
	end

	llcp_wmul u_lalb    (.clk, .adv, .a(la_s3),  .b(lb_s3),  .p(w_lalb));
	llcp_wmul u_lablab  (.clk, .adv, .a(lab_s3), .b(lab_s3), .p(w_lablab));
	llcp_wmul u_lbtad   (.clk, .adv, .a(lb_s3),  .b(tad_s3), .p(w_lbtad));
	llcp_wmul u_labtbd  (.clk, .adv, .a(lab_s3), .b(tbd_s3), .p(w_labtbd));
	llcp_wmul u_labtad  (.clk, .adv, .a(lab_s3), .b(tad_s3), .p(w_labtad));
	llcp_wmul u_latbd   (.clk, .adv, .a(la_s3),  .b(tbd_s3), .p(w_latbd));

	for (genvar i = 0; i < 3; i++) begin : g_axis
		llcp_nmul u_na (.clk, .adv, .a(numa_s9), .b(ta_d[ST_FAC][i]), .p(na_c[i]));
		llcp_nmul u_nb (.clk, .adv, .a(numb_s9), .b(tb_d[ST_FAC][i]), .p(nb_c[i]));

		llcp_div u_da (
			.clk, .adv,
			.num(na_c[i]), .den(fac_d[ST_NMUL][DENW-1:0]),
			.base(a0_d[ST_NMUL][i]), .keep(par_d[ST_NMUL]),
			.coord(ca_c[i]), .keep_out(ka_c[i])
		);
		llcp_div u_db (
			.clk, .adv,
			.num(nb_c[i]), .den(fac_d[ST_NMUL][DENW-1:0]),
			.base(b0_d[ST_NMUL][i]), .keep(par_d[ST_NMUL]),
			.coord(cb_c[i]), .keep_out(kb_c[i])
		);
	end
endmodule

FILE: design/llcp_wmul.sv
// Pipelined signed multiplier for two dot products (five register stages).
// Depends on llcp_pkg.
`timescale 1ns / 1ps

module llcp_wmul (
	input  logic          clk,
	input  logic          adv,
	input  llcp_pkg::dot_t  a,
	input  llcp_pkg::dot_t  b,
	output llcp_pkg::wide_t p
);
	import llcp_pkg::*;

	dot_t a_neg, b_neg;
	logic [2*HW-1:0] am_s1, bm_s1;
	logic            neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*HW-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [4*HW-1:0] ev_s3;
	logic [2*HW:0]   od_s3;
	logic [4*HW-1:0] mag_s4;
	wide_t           p_s5;

	assign a_neg = -a;
	assign b_neg = -b;
	assign p = p_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			am_s1  <= a[PW-1] ? a_neg[PW-2:0] : a[PW-2:0];
			bm_s1  <= b[PW-1] ? b_neg[PW-2:0] : b[PW-2:0];
			neg_s1 <= a[PW-1] ^ b[PW-1];

			// 33x33 partial products
			p00_s2 <= am_s1[HW-1:0] * bm_s1[HW-1:0];
			p01_s2 <= am_s1[HW-1:0] * bm_s1[2*HW-1:HW];
			p10_s2 <= am_s1[2*HW-1:HW] * bm_s1[HW-1:0];
			p11_s2 <= am_s1[2*HW-1:HW] * bm_s1[2*HW-1:HW];
			neg_s2 <= neg_s1;

			ev_s3  <= {p11_s2, p00_s2};
			od_s3  <= (2*HW+1)'(p01_s2) + (2*HW+1)'(p10_s2);
			neg_s3 <= neg_s2;

			mag_s4 <= ev_s3 + ((4*HW)'(od_s3) << HW);
			neg_s4 <= neg_s3;

			p_s5   <= neg_s4 ? -FW'(mag_s4) : FW'(mag_s4);
		end
	end
endmodule

FILE: design/llcp_nmul.sv
// Pipelined signed multiplier: numerator times an edge component (five stages).
// Depends on llcp_pkg.
`timescale 1ns / 1ps

module llcp_nmul (
	input  logic           clk,
	input  logic           adv,
	input  llcp_pkg::wide_t a,
	input  llcp_pkg::diff_t b,
	output llcp_pkg::num_t  p
);
	import llcp_pkg::*;

	localparam int AMW = NSL * KW;
	localparam int PPW = KW + DW - 1;
	localparam int MW  = AMW + DW - 1;

	wide_t           a_neg;
	diff_t           b_neg;
	logic [AMW-1:0]  am_s1;
	logic [DW-2:0]   bm_s1;
	logic            neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PPW-1:0]  pp_s2 [NSL];
	logic [MW-1:0]   ev_c, od_c;
	logic [MW-1:0]   ev_s3, od_s3;
	logic [MW-1:0]   mag_s4;
	num_t            p_s5;

	assign a_neg = -a;
	assign b_neg = -b;
	assign p = p_s5;

	// even slices never overlap, nor do odd ones
	always_comb begin
		ev_c = '0;
		od_c = '0;
		for (int i = 0; i < NSL; i++) begin
			if (i % 2 == 0)
				ev_c = ev_c | (MW'(pp_s2[i]) << (i * KW));
			else
				od_c = od_c | (MW'(pp_s2[i]) << (i * KW));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			am_s1  <= AMW'(a[FW-1] ? a_neg[FW-2:0] : a[FW-2:0]);
			bm_s1  <= b[DW-1] ? b_neg[DW-2:0] : b[DW-2:0];
			neg_s1 <= a[FW-1] ^ b[DW-1];

			for (int i = 0; i < NSL; i++)
				pp_s2[i] <= am_s1[i*KW +: KW] * bm_s1;
			neg_s2 <= neg_s1;

			ev_s3  <= ev_c;
			od_s3  <= od_c;
			neg_s3 <= neg_s2;

			mag_s4 <= ev_s3 + od_s3;
			neg_s4 <= neg_s3;

			p_s5   <= neg_s4 ? -NW'(mag_s4) : NW'(mag_s4);
		end
	end
endmodule

FILE: design/llcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding,
// clamping and the final add of the start point. Depends on llcp_pkg.
`timescale 1ns / 1ps

module llcp_div (
	input  logic             clk,
	input  logic             adv,
	input  llcp_pkg::num_t   num,
	input  llcp_pkg::den_t   den,
	input  llcp_pkg::coord_t base,
	input  logic             keep,
	output llcp_pkg::coord_t coord,
	output logic             keep_out
);
	import llcp_pkg::*;

	num_t            num_neg;
	logic [NW-2:0]   nmag_p0;
	logic            neg_p0, keep_p0;
	den_t            den_p0;
	coord_t          base_p0;
	logic [DENW-1:0] hi_c;

	logic [DENW-1:0] rem_s [QW+1];
	logic [QB-1:0]   nlo_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	den_t            den_s [QW+1];
	dctl_t           ctl_s [QW+1];

	logic [DENW:0]   rs_c [QW];
	logic [DENW:0]   rd_c [QW];
	logic            ge_c [QW];

	logic [QW-1:0]   qr_c;
	logic [QB-1:0]   qm_c;
	logic            big_c;
	logic signed [QW-1:0]   sq_f1;
	coord_t          base_f1;
	logic            keep_f1;
	logic signed [SUMW-1:0] sum_c;
	coord_t          coord_f2;
	logic            keep_f2;

	assign num_neg = -num;
	assign hi_c = DENW'(nmag_p0[NW-2:QB]);

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			rs_c[k] = {rem_s[k], nlo_s[k][QB-1]};
			rd_c[k] = rs_c[k] - {1'b0, den_s[k]};
			ge_c[k] = rs_c[k] >= {1'b0, den_s[k]};
		end
	end

	// low bit of the quotient is the round-half-away bit
	assign qr_c  = {1'b0, quo_s[QW][QW-1:1]} + QW'(quo_s[QW][0]);
	assign big_c = ctl_s[QW].ovf | (|qr_c[QW-1:QB-1]);
	assign qm_c  = big_c ? QCLAMP : qr_c[QB-1:0];
	assign sum_c = SUMW'(base_f1) + SUMW'(sq_f1);

	assign coord    = coord_f2;
	assign keep_out = keep_f2;

	always_ff @(posedge clk) begin
		if (adv) begin
			nmag_p0 <= num[NW-1] ? num_neg[NW-2:0] : num[NW-2:0];
			neg_p0  <= num[NW-1];
			den_p0  <= den;
			base_p0 <= base;
			keep_p0 <= keep;

			rem_s[0] <= hi_c;
			nlo_s[0] <= nmag_p0[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den_p0;
			ctl_s[0] <= '{base: base_p0, keep: keep_p0, neg: neg_p0, ovf: (hi_c >= den_p0)};

			for (int k = 0; k < QW; k++) begin
				rem_s[k+1] <= ge_c[k] ? rd_c[k][DENW-1:0] : rs_c[k][DENW-1:0];
				nlo_s[k+1] <= {nlo_s[k][QB-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge_c[k]};
				den_s[k+1] <= den_s[k];
				ctl_s[k+1] <= ctl_s[k];
			end

			sq_f1   <= ctl_s[QW].neg ? -$signed({1'b0, qm_c}) : $signed({1'b0, qm_c});
			base_f1 <= ctl_s[QW].base;
			keep_f1 <= ctl_s[QW].keep;

			if (keep_f1)
				coord_f2 <= base_f1;
			else if (sum_c > SUM_MAX)
				coord_f2 <= COORD_WIDTH'(SUM_MAX);
			else if (sum_c < SUM_MIN)
				coord_f2 <= COORD_WIDTH'(SUM_MIN);
			else
				coord_f2 <= COORD_WIDTH'(sum_c);
			keep_f2 <= keep_f1;
		end
	end
endmodule
